>>> design/size_class_pool_allocator_unit_defines.svh
// Assertion macros used by the checker file of the allocator.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define SCPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset cycles included.
`define SCPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/scpa_pkg.sv
package scpa_pkg;

  // Pool geometry and size classes.
  localparam int POOL_BYTES   = 65536;
  localparam int CLASS_COUNT  = 12;
  localparam int HEADER_BYTES = 8;
  localparam int MIN_BLOCK    = 8;

  // Field widths.
  localparam int OFF_W  = 16;
  localparam int SIZE_W = 17;
  localparam int CLS_W  = $clog2(CLASS_COUNT);

  // Block header store: one entry per 8-byte granule of the pool.
  localparam int HDR_DEPTH = POOL_BYTES / 8;
  localparam int HDR_AW    = $clog2(HDR_DEPTH);
  localparam int HDR_W     = CLS_W + 1 + OFF_W;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_BIG   = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  // A classified request as it waits in the queue.
  typedef struct packed {
    logic             is_free;
    logic             too_big;
    logic             ignore;
    logic [CLS_W-1:0] cls;
    logic [OFF_W-1:0] free_start;
  } cmd_t;

  // One block header entry.
  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic             link_valid;
    logic [OFF_W-1:0] link;
  } hdr_t;

  // One free-list head.
  typedef struct packed {
    logic             valid;
    logic [OFF_W-1:0] start;
  } head_t;

  typedef struct packed {
    logic             ok;
    logic [CLS_W-1:0] cls;
  } cls_res_t;

  // Smallest class whose block holds the requested size.
  function automatic cls_res_t classify(input logic [OFF_W-1:0] req);
    cls_res_t r;
    r.ok  = 1'b0;
    r.cls = '0;
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if (32'(req) <= (32'(MIN_BLOCK) << i)) begin
        r.ok  = 1'b1;
        r.cls = CLS_W'(i);
      end
    end
    return r;
  endfunction

  // Data bytes of a block of the given class.
  function automatic logic [SIZE_W-1:0] block_bytes(input logic [CLS_W-1:0] cls);
    return SIZE_W'(MIN_BLOCK) << cls;
  endfunction

endpackage

>>> design/scpa_ram.sv
module scpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/scpa_front.sv
module scpa_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [scpa_pkg::OFF_W-1:0] in_request_size,
  input  logic [scpa_pkg::OFF_W-1:0] in_free_offset,
  input  logic                       pop,
  output logic                       q_valid,
  output scpa_pkg::cmd_t             q_cmd
);
  import scpa_pkg::*;

  cmd_t       entry_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_c;
  cls_res_t   cls_c;

  // Classify the incoming request.
  always_comb begin
    cls_c            = classify(in_request_size);
    cmd_c.is_free    = (in_op == OP_FREE);
    cmd_c.too_big    = (in_op == OP_ALLOC) && !cls_c.ok;
    cmd_c.ignore     = (in_free_offset < OFF_W'(HEADER_BYTES));
    cmd_c.cls        = cls_c.cls;
    cmd_c.free_start = in_free_offset - OFF_W'(HEADER_BYTES);
  end

  // Two-entry queue toward the back end.
  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = entry_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= cmd_c;
    end
  end

endmodule

>>> design/scpa_back.sv
module scpa_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [scpa_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                        q_valid,
  input  scpa_pkg::cmd_t              q_cmd,
  output logic                        pop,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [scpa_pkg::OFF_W-1:0]  out_data_offset
);
  import scpa_pkg::*;

  typedef enum logic [1:0] {
    S_FETCH = 2'b01,
    S_EXEC  = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cur_r;
  head_t               hsel_r;
  logic [SIZE_W-1:0]   bump_r, bump_nxt;
  logic [SIZE_W-1:0]   pool_size_r;
  logic                head_valid_r [CLASS_COUNT];
  logic [OFF_W-1:0]    head_start_r [CLASS_COUNT];

  // Shared read port of the list heads.
  logic [CLS_W-1:0]    hrd_idx;
  logic                hrd_ok;
  head_t               hrd;

  // Header store signals.
  logic                mem_we, mem_re;
  logic [HDR_AW-1:0]   mem_waddr, mem_raddr;
  hdr_t                mem_wdata;
  logic [HDR_W-1:0]    mem_rdata;
  hdr_t                rd_hdr;

  // Execute-stage signals.
  logic                head_we;
  logic [CLS_W-1:0]    head_widx;
  head_t               head_wval;
  logic [SIZE_W-1:0]   need;
  logic [SIZE_W-1:0]   limit;
  logic [SIZE_W:0]     bump_sum;
  logic                fit;
  status_t             status_c;
  logic [OFF_W-1:0]    data_c;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [OFF_W-1:0]    out_data_r;

  assign rd_hdr = hdr_t'(mem_rdata);

  // The fetch step reads the head of the queued request's class, the
  // execute step reads the head of the class found in the block header.
  always_comb begin
    hrd_idx   = (state_r == S_EXEC) ? rd_hdr.cls : q_cmd.cls;
    hrd_ok    = (hrd_idx < CLS_W'(CLASS_COUNT));
    hrd.valid = hrd_ok ? head_valid_r[hrd_idx] : 1'b0;
    hrd.start = hrd_ok ? head_start_r[hrd_idx] : '0;
  end

  // Fetch: take a request from the queue and start the header read.
  assign pop       = (state_r == S_FETCH) && q_valid;
  assign mem_re    = pop;
  assign mem_raddr = q_cmd.is_free ? q_cmd.free_start[OFF_W-1:3] : hrd.start[OFF_W-1:3];

  // Bump carving check.
  always_comb begin
    need     = SIZE_W'(HEADER_BYTES) + block_bytes(cur_r.cls);
    limit    = (pool_size_r > SIZE_W'(POOL_BYTES)) ? SIZE_W'(POOL_BYTES) : pool_size_r;
    bump_sum = {1'b0, bump_r} + {1'b0, need};
    fit      = (bump_sum <= {1'b0, limit});
  end

  // Execute: header write, list head update and result.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    head_we   = 1'b0;
    head_widx = '0;
    head_wval = '0;
    bump_nxt  = bump_r;
    status_c  = ST_OK;
    data_c    = '0;
    if (state_r == S_EXEC) begin
      priority if (cur_r.too_big) begin
        status_c = ST_TOO_BIG;
      end else if (!cur_r.is_free && hsel_r.valid) begin
        // Pop the class's free list.
        data_c               = hsel_r.start + OFF_W'(HEADER_BYTES);
        mem_we               = 1'b1;
        mem_waddr            = hsel_r.start[OFF_W-1:3];
        mem_wdata.cls        = rd_hdr.cls;
        head_we              = 1'b1;
        head_widx            = cur_r.cls;
        head_wval.valid      = rd_hdr.link_valid;
        head_wval.start      = rd_hdr.link;
      end else if (!cur_r.is_free) begin
        // Carve a new block from the bump pointer.
        if (fit) begin
          data_c        = bump_r[OFF_W-1:0] + OFF_W'(HEADER_BYTES);
          mem_we        = 1'b1;
          mem_waddr     = bump_r[OFF_W-1:3];
          mem_wdata.cls = cur_r.cls;
          bump_nxt      = bump_sum[SIZE_W-1:0];
        end else begin
          status_c = ST_EXHAUSTED;
        end
      end else if (!cur_r.ignore && hrd_ok) begin
        // Push the freed block onto its class's list.
        mem_we               = 1'b1;
        mem_waddr            = cur_r.free_start[OFF_W-1:3];
        mem_wdata.cls        = rd_hdr.cls;
        mem_wdata.link_valid = hrd.valid;
        mem_wdata.link       = hrd.start;
        head_we              = 1'b1;
        head_widx            = rd_hdr.cls;
        head_wval.valid      = 1'b1;
        head_wval.start      = cur_r.free_start;
      end else begin
        status_c = ST_OK;
      end
    end
  end

  // Sequencer: fetch, then execute.
  always_comb begin
    unique case (state_r)
      S_FETCH: state_nxt = q_valid ? S_EXEC : S_FETCH;
      S_EXEC:  state_nxt = S_FETCH;
      default: state_nxt = S_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FETCH;
      bump_r      <= '0;
      pool_size_r <= SIZE_W'(POOL_BYTES);
      out_valid_r <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        head_valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      bump_r      <= bump_nxt;
      out_valid_r <= (state_r == S_EXEC);
      if (cfg_we) begin
        pool_size_r <= cfg_wdata;
      end
      if (head_we) begin
        head_valid_r[head_widx] <= head_wval.valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= q_cmd;
      hsel_r <= hrd;
    end
    if (head_we) begin
      head_start_r[head_widx] <= head_wval.start;
    end
    out_status_r <= status_c;
    out_data_r   <= data_c;
  end

  scpa_ram #(
    .WIDTH(HDR_W),
    .DEPTH(HDR_DEPTH)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_offset = out_data_r;

endmodule

>>> design/size_class_pool_allocator_unit.sv
// Pool allocator with power-of-two size classes (8 bytes up to 16 KiB).
// Requests: drive in_op, in_request_size and in_free_offset with start high;
// the request is taken at a rising edge where busy is low. An allocate
// returns the data offset of a block (header plus block come from the class
// free list or are carved from the bump pointer); a free pushes the block
// back onto the list of the class stored in its header.
// Results: out_status and out_data_offset are valid for the single cycle in
// which out_valid is high. The receiver cannot hold results off.
// With the back end idle, a taken request passes the queue, the fetch step
// and the execute step; out_valid then rises from a register. The back end
// finishes one request before it takes the next, as the header store port is
// read in the fetch step and written in the execute step. A two-entry request
// queue sits in front of the back end; busy is high while it is full.
// Configuration: cfg_we with cfg_wdata writes the usable pool size; write it
// only while no request is in flight.
// Reset (rst_n low, synchronous) empties all free lists, clears the bump
// pointer and the queue, and sets the pool size to 64 KiB. The header store
// is not cleared; the user must have each header written before it is read.
module size_class_pool_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_op,
  input  logic [scpa_pkg::OFF_W-1:0]  in_request_size,
  input  logic [scpa_pkg::OFF_W-1:0]  in_free_offset,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [scpa_pkg::OFF_W-1:0]  out_data_offset,
  input  logic                        cfg_we,
  input  logic [scpa_pkg::SIZE_W-1:0] cfg_wdata
);
  import scpa_pkg::*;

  logic q_valid;
  logic pop;
  cmd_t q_cmd;

  // Front end: classify and queue requests.
  scpa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_request_size(in_request_size),
    .in_free_offset (in_free_offset),
    .pop            (pop),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd)
  );

  // Back end: list heads, bump pointer and header store.
  scpa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_data_offset(out_data_offset)
  );

endmodule

>>> design/scpa_checker.sv
`include "size_class_pool_allocator_unit_defines.svh"

module scpa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       busy,
  input logic                       out_valid,
  input logic [1:0]                 out_status,
  input logic [scpa_pkg::OFF_W-1:0] out_data_offset
);
  import scpa_pkg::*;

  // Each request occupies the header store for its fetch and execute steps.
  `SCPA_ASSERT(a_result_spacing, clk, rst_n, out_valid |=> !out_valid, "results closer than two cycles")

  // Only the defined status codes appear.
  `SCPA_ASSERT(a_status_code, clk, rst_n, out_valid |-> (out_status == ST_OK || out_status == ST_TOO_BIG || out_status == ST_EXHAUSTED), "undefined status code")

  // A failed allocate returns offset zero.
  `SCPA_ASSERT(a_fail_offset, clk, rst_n, (out_valid && out_status != ST_OK) |-> (out_data_offset == '0), "nonzero offset on failure")

  // Reset leaves the queue empty and no result pending.
  `SCPA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule

bind size_class_pool_allocator_unit scpa_checker u_scpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_data_offset(out_data_offset)
);
